[rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, opcode codes and decoded-op types for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int WORD_W     = 32;
	localparam int CMD_W      = 4;

	localparam int S_FIELDS_W = CMD_W + 2 * WORD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 2 * WORD_W + 1;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	// divider: quotient bits resolved per pipeline stage
	localparam int DIV_BPS    = 2;
	localparam int DIV_STAGES = (WORD_W + FRAC_BITS + DIV_BPS - 1) / DIV_BPS;
	localparam int DIV_BITS   = DIV_STAGES * DIV_BPS;

	// queue between front and back, power of two
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	// back end: setup stage, divider stages, output register
	localparam int PIPE_DEPTH = DIV_STAGES + 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LT      = 4'd0,
		CMD_GT      = 4'd1,
		CMD_LE      = 4'd2,
		CMD_GE      = 4'd3,
		CMD_EQ      = 4'd4,
		CMD_NE      = 4'd5,
		CMD_ADD     = 4'd6,
		CMD_SUB     = 4'd7,
		CMD_MUL     = 4'd8,
		CMD_DIV     = 4'd9,
		CMD_PREINC  = 4'd10,
		CMD_POSTINC = 4'd11,
		CMD_PREDEC  = 4'd12,
		CMD_POSTDEC = 4'd13
	} fpa_cmd_t;

	typedef enum logic [2:0] {
		UNIT_NONE,
		UNIT_CMP,
		UNIT_ADD,
		UNIT_MUL,
		UNIT_DIV,
		UNIT_STEP
	} fpa_unit_t;

	typedef struct packed {
		fpa_unit_t unit;
		logic      sub;     // subtract / decrement
		logic      pre;     // step ops: value is the new a
		logic      sel_lt;  // compare: flag set when a < b
		logic      sel_eq;
		logic      sel_gt;
	} fpa_uop_t;

	typedef struct packed {
		fpa_uop_t          uop;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} fpa_item_t;

endpackage

[rtl/fpa_front.sv]
// ----------------------------------------------------------------------------
// fpa_front
// Input side: takes transactions and decodes the opcode into a micro-op.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 q_full,
	output logic                 push,
	output fpa_item_t            item
);

	fpa_cmd_t cmd;
	fpa_uop_t uop;

	assign cmd = fpa_cmd_t'(s_tdata[CMD_W-1:0]);

	always_comb begin
		uop      = '0;
		uop.unit = UNIT_NONE;
		unique case (cmd)
			CMD_LT: begin
				uop.unit   = UNIT_CMP;
				uop.sel_lt = 1'b1;
			end
			CMD_GT: begin
				uop.unit   = UNIT_CMP;
				uop.sel_gt = 1'b1;
			end
			CMD_LE: begin
				uop.unit   = UNIT_CMP;
				uop.sel_lt = 1'b1;
				uop.sel_eq = 1'b1;
			end
			CMD_GE: begin
				uop.unit   = UNIT_CMP;
				uop.sel_gt = 1'b1;
				uop.sel_eq = 1'b1;
			end
			CMD_EQ: begin
				uop.unit   = UNIT_CMP;
				uop.sel_eq = 1'b1;
			end
			CMD_NE: begin
				uop.unit   = UNIT_CMP;
				uop.sel_lt = 1'b1;
				uop.sel_gt = 1'b1;
			end
			CMD_ADD: begin
				uop.unit = UNIT_ADD;
			end
			CMD_SUB: begin
				uop.unit = UNIT_ADD;
				uop.sub  = 1'b1;
			end
			CMD_MUL: begin
				uop.unit = UNIT_MUL;
			end
			CMD_DIV: begin
				uop.unit = UNIT_DIV;
			end
			CMD_PREINC: begin
				uop.unit = UNIT_STEP;
				uop.pre  = 1'b1;
			end
			CMD_POSTINC: begin
				uop.unit = UNIT_STEP;
			end
			CMD_PREDEC: begin
				uop.unit = UNIT_STEP;
				uop.sub  = 1'b1;
				uop.pre  = 1'b1;
			end
			CMD_POSTDEC: begin
				uop.unit = UNIT_STEP;
				uop.sub  = 1'b1;
			end
			default: begin
				uop.unit = UNIT_NONE;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;
	assign item.uop = uop;
	assign item.a   = s_tdata[CMD_W +: WORD_W];
	assign item.b   = s_tdata[CMD_W + WORD_W +: WORD_W];

endmodule

[rtl/fpa_queue.sv]
// ----------------------------------------------------------------------------
// fpa_queue
// Short flop-based FIFO of decoded items between the front and back ends.
// ----------------------------------------------------------------------------
module fpa_queue import fpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  fpa_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      valid,
	output fpa_item_t head
);

	fpa_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

endmodule

[rtl/fpa_back.sv]
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: setup stage with multiplier and adder, pipelined
// restoring divider, and the output register.
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  fpa_item_t            head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	typedef struct packed {
		logic [WORD_W-1:0]   value;
		logic [WORD_W-1:0]   upd;
		logic                flag;
		logic                is_div;
		logic                neg;
		logic                zero;
		logic [WORD_W-1:0]   den;
		logic [WORD_W-1:0]   rem;
		logic [DIV_BITS-1:0] nq;    // numerator shifts out, quotient shifts in
	} fpa_dv_t;

	function automatic fpa_dv_t div_steps(fpa_dv_t d);
		fpa_dv_t         r;
		logic [WORD_W:0] r2;
		logic            ge;
		r = d;
		for (int i = 0; i < DIV_BPS; i++) begin
			r2    = {r.rem, r.nq[DIV_BITS-1]};
			ge    = (r2 >= {1'b0, r.den});
			r.rem = ge ? WORD_W'(r2 - {1'b0, r.den}) : r2[WORD_W-1:0];
			r.nq  = {r.nq[DIV_BITS-2:0], ge};
		end
		return r;
	endfunction

	logic adv;

	// setup stage
	logic                     lt, eq, gt;
	logic [WORD_W-1:0]        opnd, sum, mag_a, mag_b;
	logic [WORD_W-1:0]        value_c, upd_c;
	logic                     flag_c;
	logic signed [2*WORD_W-1:0] prod_c;

	logic                     v_s1;
	fpa_unit_t                unit_s1;
	logic [WORD_W-1:0]        value_s1, upd_s1, den_s1;
	logic                     flag_s1, neg_s1, zero_s1;
	logic [2*WORD_W-1:0]      prod_s1;
	logic [DIV_BITS-1:0]      num_s1;

	// divider stages s2 onward
	fpa_dv_t                  d0;
	fpa_dv_t                  dv_nx [DIV_STAGES];
	fpa_dv_t                  dv_s2 [DIV_STAGES];
	logic [DIV_STAGES-1:0]    v_s2;

	fpa_dv_t                  last;
	logic [WORD_W-1:0]        quo, div_val;

	logic                     out_valid_q;
	logic [WORD_W-1:0]        out_value_q, out_upd_q;
	logic                     out_flag_q;

	// whole pipeline moves together; the output register is the only hold point
	assign adv = !out_valid_q || m_tready;
	assign pop = q_valid && adv;

	assign lt     = $signed(head.a) < $signed(head.b);
	assign eq     = (head.a == head.b);
	assign gt     = !lt && !eq;
	assign opnd   = (head.uop.unit == UNIT_STEP) ? WORD_W'(1) : head.b;
	assign sum    = head.a + (head.uop.sub ? ~opnd : opnd) + WORD_W'(head.uop.sub);
	assign mag_a  = head.a[WORD_W-1] ? (WORD_W'(0) - head.a) : head.a;
	assign mag_b  = head.b[WORD_W-1] ? (WORD_W'(0) - head.b) : head.b;
	assign prod_c = $signed(head.a) * $signed(head.b);

	always_comb begin
		value_c = '0;
		flag_c  = 1'b0;
		upd_c   = head.a;
		case (head.uop.unit)
			UNIT_CMP: begin
				flag_c = (head.uop.sel_lt & lt) | (head.uop.sel_eq & eq) |
					(head.uop.sel_gt & gt);
			end
			UNIT_ADD: begin
				value_c = sum;
			end
			UNIT_STEP: begin
				upd_c   = sum;
				value_c = head.uop.pre ? sum : head.a;
			end
			default: begin
				value_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= {v_s2[DIV_STAGES-2:0], v_s1};
			out_valid_q <= v_s2[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_s1  <= head.uop.unit;
			value_s1 <= value_c;
			flag_s1  <= flag_c;
			upd_s1   <= upd_c;
			prod_s1  <= prod_c;
			den_s1   <= mag_b;
			num_s1   <= DIV_BITS'(mag_a) << FRAC_BITS;
			neg_s1   <= head.a[WORD_W-1] ^ head.b[WORD_W-1];
			zero_s1  <= (head.a == '0) || (head.b == '0);
		end
	end

	always_comb begin
		d0.value  = (unit_s1 == UNIT_MUL) ? prod_s1[FRAC_BITS +: WORD_W] : value_s1;
		d0.upd    = upd_s1;
		d0.flag   = flag_s1;
		d0.is_div = (unit_s1 == UNIT_DIV);
		d0.neg    = neg_s1;
		d0.zero   = zero_s1;
		d0.den    = den_s1;
		d0.rem    = '0;
		d0.nq     = num_s1;
	end

	always_comb begin
		dv_nx[0] = div_steps(d0);
		for (int k = 1; k < DIV_STAGES; k++) begin
			dv_nx[k] = div_steps(dv_s2[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				dv_s2[k] <= dv_nx[k];
			end
		end
	end

	assign last    = dv_s2[DIV_STAGES-1];
	assign quo     = last.nq[WORD_W-1:0];
	assign div_val = last.zero ? '0 : (last.neg ? (WORD_W'(0) - quo) : quo);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= last.is_div ? div_val : last.value;
			out_flag_q  <= last.flag;
			out_upd_q   <= last.upd;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_upd_q, out_flag_q, out_value_q});

endmodule

[rtl/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Takes one operation per clock while the output side is not stalled and
// returns one result per operation, in order. Each transaction runs a fixed
// pipeline: the input queue, a setup stage (adder, comparator, 32x32
// multiplier), DIV_STAGES divider stages resolving DIV_BPS quotient bits
// each, and the output register. Every operation passes through the divider
// pipeline so ordering is kept. A stalled output freezes the pipeline, and
// the four-entry input queue keeps s_tready high until it fills.
module fixed_point_alu import fpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // cmd[3:0], operand_a[35:4], operand_b[67:36]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // value[31:0], flag[32], updated_a[64:33]
);

	logic      q_full;
	logic      push;
	fpa_item_t push_item;
	logic      pop;
	logic      q_valid;
	fpa_item_t head;

	fpa_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.item     (push_item)
	);

	fpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (head)
	);

	fpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[rtl/fpa_checker.sv]
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks for the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker import fpa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	localparam int CAP   = QDEPTH + PIPE_DEPTH;
	localparam int CHK_W = $clog2(CAP + 1);

	logic [CHK_W-1:0] cnt_q;   // transactions in flight
	logic             in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   cnt_q <= cnt_q + CHK_W'(1);
				2'b01:   cnt_q <= cnt_q - CHK_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("m_tdata changed while stalled");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != '0)
		else $error("result offered with nothing in flight");

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> cnt_q >= CHK_W'(QDEPTH))
		else $error("input stalled before queue filled");

	a_in_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CHK_W'(CAP))
		else $error("more transactions in flight than storage");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[sim/fixed_point_alu_test.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu_test
// Self-checking bench for the signed Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
// A directed set covers the corners of each opcode: compare edges, add and
// subtract wrap, multiply and divide sign handling, divide by or of zero,
// divide overflow, step ops at the range limits and the unused opcodes.
// Random operations follow. The driver sends them in bursts with random gaps
// and pauses twice until the pipeline is empty. The monitor stalls the output
// on its own pattern and checks every transaction against an in-bench model.
// ----------------------------------------------------------------------------
module fixed_point_alu_test;
	import fpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM    = 1550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_MAX    = 10;

	// opcodes the block does not define
	localparam logic [CMD_W-1:0] CMD_RSVD_E = 4'd14;
	localparam logic [CMD_W-1:0] CMD_RSVD_F = 4'd15;

	localparam logic [WORD_W-1:0] W_MIN = 32'h8000_0000;
	localparam logic [WORD_W-1:0] W_MAX = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] W_ONE = 32'h0000_0001;
	localparam logic [WORD_W-1:0] W_NEG = 32'hffff_ffff;

	typedef struct packed {
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] a;
		logic [CMD_W-1:0]  cmd;
	} alu_op_t;

	typedef struct packed {
		logic [WORD_W-1:0] upd_a;
		logic              flag;
		logic [WORD_W-1:0] value;
	} alu_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	alu_op_t  pending_ops[$];
	alu_res_t expected_res[$];

	int n_in = 0;
	int n_out = 0;
	int n_sent = 0;
	int n_errors = 0;
	int drain_a = 0;
	int drain_b = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rdy_mode = 0;
	int rdy_left = 0;
	int rdy_phase = 0;
	int cycles = 0;

	fixed_point_alu u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic alu_res_t alu_predict(alu_op_t op);
		alu_res_t          r;
		logic signed [63:0] prod;
		logic signed [63:0] prod_sh;
		logic [63:0]       num;
		logic [63:0]       quo;
		logic [WORD_W-1:0] mag_a;
		logic [WORD_W-1:0] mag_b;
		r.value = '0;
		r.flag  = 1'b0;
		r.upd_a = op.a;
		case (op.cmd)
			CMD_LT: r.flag = $signed(op.a) < $signed(op.b);
			CMD_GT: r.flag = $signed(op.a) > $signed(op.b);
			CMD_LE: r.flag = $signed(op.a) <= $signed(op.b);
			CMD_GE: r.flag = $signed(op.a) >= $signed(op.b);
			CMD_EQ: r.flag = op.a == op.b;
			CMD_NE: r.flag = op.a != op.b;
			CMD_ADD: r.value = op.a + op.b;
			CMD_SUB: r.value = op.a - op.b;
			CMD_MUL: begin
				prod    = {{32{op.a[31]}}, op.a} * {{32{op.b[31]}}, op.b};
				prod_sh = prod >>> FRAC_BITS;
				r.value = prod_sh[WORD_W-1:0];
			end
			CMD_DIV: begin
				if (op.a != '0 && op.b != '0) begin
					mag_a = op.a[31] ? -op.a : op.a;
					mag_b = op.b[31] ? -op.b : op.b;
					num   = {32'b0, mag_a} << FRAC_BITS;
					quo   = num / {32'b0, mag_b};
					if (op.a[31] ^ op.b[31]) begin
						quo = -quo;
					end
					r.value = quo[WORD_W-1:0];
				end
			end
			CMD_PREINC: begin
				r.upd_a = op.a + 1'b1;
				r.value = r.upd_a;
			end
			CMD_POSTINC: begin
				r.upd_a = op.a + 1'b1;
				r.value = op.a;
			end
			CMD_PREDEC: begin
				r.upd_a = op.a - 1'b1;
				r.value = r.upd_a;
			end
			CMD_POSTDEC: begin
				r.upd_a = op.a - 1'b1;
				r.value = op.a;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic add_op(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		alu_op_t op;
		op.cmd = cmd;
		op.a   = a;
		op.b   = b;
		pending_ops.push_back(op);
	endtask

	// mostly full-range, with a share of small values and range corners
	function automatic logic [WORD_W-1:0] rand_operand();
		logic [WORD_W-1:0] v;
		case ($urandom_range(0, 9))
			5: v = $urandom_range(0, 2048) - 1024;
			6: begin
				case ($urandom_range(0, 6))
					0: v = W_MIN;
					1: v = W_MAX;
					2: v = '0;
					3: v = W_ONE;
					4: v = W_NEG;
					5: v = 32'h0000_0100;
					default: v = 32'hffff_ff00;
				endcase
			end
			7: v = W_ONE << $urandom_range(0, 31);
			8, 9: v = $urandom_range(1, 1 << 20) * ($urandom_range(0, 1) ? 1 : -1);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// driver: one transaction in flight on the input, bursts and gaps between
	always @(posedge clk or negedge arst_n) begin : drive_blk
		int      issued;
		alu_op_t nxt;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			issued = n_sent;
			if (s_tvalid) begin
				void'(pending_ops.pop_front());
				issued = issued + 1;
			end
			n_sent <= issued;
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_ops.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if ((issued == drain_a || issued == drain_b) &&
					(s_tvalid || n_in != n_out)) begin
				// hold off until every result has come back
				s_tvalid <= 1'b0;
			end else begin
				nxt      = pending_ops[0];
				s_tdata  <= S_TDATA_W'(nxt);
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					if ($urandom_range(0, 4) == 0) begin
						burst_left <= $urandom_range(100, 300);
					end else begin
						burst_left <= $urandom_range(1, 40);
					end
					gap_left <= $urandom_range(0, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// monitor: predicts on input transactions, checks output transactions
	always @(posedge clk or negedge arst_n) begin : check_blk
		alu_res_t got;
		alu_res_t want;
		alu_op_t  op;
		if (!arst_n) begin
			m_tready <= 1'b0;
			n_in     <= 0;
			n_out    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = alu_res_t'(m_tdata[$bits(alu_res_t)-1:0]);
				if (expected_res.size() == 0) begin
					if (n_errors < SHOW_MAX) begin
						$display("unexpected result: value=%h flag=%b updated_a=%h",
							got.value, got.flag, got.upd_a);
					end
					n_errors = n_errors + 1;
				end else begin
					want = expected_res.pop_front();
					n_out <= n_out + 1;
					if (got.value !== want.value || got.flag !== want.flag ||
							got.upd_a !== want.upd_a) begin
						if (n_errors < SHOW_MAX) begin
							$display("mismatch on result %0d: exp value=%h flag=%b updated_a=%h, got value=%h flag=%b updated_a=%h",
								n_out, want.value, want.flag, want.upd_a,
								got.value, got.flag, got.upd_a);
						end
						n_errors = n_errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				op = alu_op_t'(s_tdata[$bits(alu_op_t)-1:0]);
				expected_res.push_back(alu_predict(op));
				n_in <= n_in + 1;
			end
			// output stall pattern: free run, coin flip, fixed 5-of-8, long stalls
			if (rdy_left == 0) begin
				rdy_mode <= $urandom_range(0, 3);
				rdy_left <= $urandom_range(30, 300);
			end else begin
				rdy_left <= rdy_left - 1;
			end
			rdy_phase <= rdy_phase + 1;
			case (rdy_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rdy_phase % 8) < 5;
				default: m_tready <= $urandom_range(0, 15) == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout: %0d results outstanding", n_in - n_out);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		alu_op_t op;
		// directed corners
		add_op(CMD_LT, W_MIN, W_MAX);
		add_op(CMD_LT, W_MAX, W_MIN);
		add_op(CMD_GT, W_NEG, '0);
		add_op(CMD_LE, 32'd5, 32'd5);
		add_op(CMD_GE, W_MIN, W_MIN);
		add_op(CMD_EQ, 32'h1234_5678, 32'h1234_5678);
		add_op(CMD_NE, '0, W_NEG);
		add_op(CMD_ADD, W_MAX, W_ONE);
		add_op(CMD_SUB, W_MIN, W_ONE);
		add_op(CMD_MUL, W_MIN, W_MIN);
		add_op(CMD_MUL, W_MAX, W_NEG);
		add_op(CMD_MUL, 32'h0000_0100, 32'h0000_0100);
		add_op(CMD_MUL, 32'hffff_fe80, 32'h0000_0200);
		add_op(CMD_DIV, '0, 32'd5);
		add_op(CMD_DIV, 32'd5, '0);
		add_op(CMD_DIV, W_MIN, W_NEG);
		add_op(CMD_DIV, W_MAX, W_ONE);
		add_op(CMD_DIV, 32'hffff_fd00, 32'h0000_0200);
		add_op(CMD_DIV, W_ONE, W_MAX);
		add_op(CMD_PREINC, W_MAX, $urandom);
		add_op(CMD_POSTINC, W_MAX, $urandom);
		add_op(CMD_PREDEC, W_MIN, $urandom);
		add_op(CMD_POSTDEC, W_MIN, $urandom);
		add_op(CMD_PREINC, W_NEG, '0);
		add_op(CMD_RSVD_E, $urandom, $urandom);
		add_op(CMD_RSVD_F, $urandom, $urandom);
		drain_a = pending_ops.size();
		drain_b = drain_a + 700;

		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				op.cmd = $urandom_range(0, 1) ? CMD_RSVD_F : CMD_RSVD_E;
			end else begin
				op.cmd = CMD_W'($urandom_range(0, 13));
			end
			op.a = rand_operand();
			// equal operands now and then so compares hit the boundary
			op.b = ($urandom_range(0, 7) == 0) ? op.a : rand_operand();
			pending_ops.push_back(op);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (n_in != n_out) begin
			@(posedge clk);
		end
		repeat (PIPE_DEPTH * 3) @(posedge clk);

		if (expected_res.size() != 0) begin
			$display("%0d results never arrived", expected_res.size());
		end
		if (n_errors == 0 && expected_res.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
